>>> hw/rtl/aes_pkg.sv
// Shared types, constants and GF(2^8) helpers for the AES-128 CBC unit.
`default_nettype none
package aes_pkg;
  localparam int unsigned BlockW = 128;
  localparam int unsigned KeyW   = 128;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [CfgIdxW-1:0] RegKeyHigh = 1'b0;
  localparam logic [CfgIdxW-1:0] RegKeyLow  = 1'b1;

  typedef enum logic {
    OpEncrypt = 1'b0,
    OpDecrypt = 1'b1
  } op_e;

  // Byte substitution, forward and inverse, as functions (constant tables).
  function automatic logic [7:0] sbox_f(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    return t[a];
  endfunction

  function automatic logic [7:0] inv_sbox_f(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };
    return t[a];
  endfunction

  function automatic logic [7:0] xtime_f(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // One column of MixColumns or InvMixColumns; bytes [31:24] are row 0.
  function automatic logic [31:0] mix_col_f(input logic [31:0] c, input logic inv);
    logic [7:0] a [4];
    logic [7:0] x2 [4];
    logic [7:0] x4 [4];
    logic [7:0] x8 [4];
    logic [7:0] m0, m1, m2, m3;
    logic [31:0] r;
    r = '0;
    for (int i = 0; i < 4; i++) begin
      a[i]  = c[31-8*i -: 8];
      x2[i] = xtime_f(a[i]);
      x4[i] = xtime_f(x2[i]);
      x8[i] = xtime_f(x4[i]);
    end
    for (int i = 0; i < 4; i++) begin
      if (inv) begin
        m0 = x8[i] ^ x4[i] ^ x2[i];
        m1 = x8[(i+1)%4] ^ x2[(i+1)%4] ^ a[(i+1)%4];
        m2 = x8[(i+2)%4] ^ x4[(i+2)%4] ^ a[(i+2)%4];
        m3 = x8[(i+3)%4] ^ a[(i+3)%4];
      end else begin
        m0 = x2[i];
        m1 = x2[(i+1)%4] ^ a[(i+1)%4];
        m2 = a[(i+2)%4];
        m3 = a[(i+3)%4];
      end
      r[31-8*i -: 8] = m0 ^ m1 ^ m2 ^ m3;
    end
    return r;
  endfunction
endpackage
`default_nettype wire

>>> hw/rtl/aes_ram.sv
// Generic single-port RAM with registered read.
`default_nettype none
module aes_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 44
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule
`default_nettype wire

>>> hw/rtl/aes_key_exp.sv
// Key expansion sequencer: one round-key word per cycle into the key RAM.
`default_nettype none
module aes_key_exp (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  input  wire logic [127:0] key_i,
  output logic              busy_o,
  output logic              we_o,
  output logic [5:0]        addr_o,
  output logic [31:0]       wdata_o
);
  import aes_pkg::*;

  logic [127:0] win_q;   // last four words, oldest in the top
  logic [5:0]   idx_q;
  logic [7:0]   rc_q;
  logic         busy_q;
  logic [31:0]  t, w_new;

  always_comb begin
    t = win_q[31:0];
    if (idx_q[1:0] == 2'd0) begin
      t = {sbox_f(t[23:16]), sbox_f(t[15:8]), sbox_f(t[7:0]), sbox_f(t[31:24])}
          ^ {rc_q, 24'd0};
    end
    w_new = win_q[127:96] ^ t;
  end

  // Words 0..3 come straight from the key.
  assign we_o    = busy_q;
  assign addr_o  = idx_q;
  assign wdata_o = (idx_q < 6'd4) ? key_i[127-32*idx_q[1:0] -: 32] : w_new;
  assign busy_o  = busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
      idx_q  <= '0;
      rc_q   <= 8'h01;
    end else if (start_i) begin
      busy_q <= 1'b1;
      idx_q  <= '0;
      rc_q   <= 8'h01;
    end else if (busy_q) begin
      idx_q <= idx_q + 6'd1;
      if (idx_q >= 6'd4 && idx_q[1:0] == 2'd0) begin
        rc_q <= xtime_f(rc_q);
      end
      if (idx_q == 6'd43) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      win_q <= {win_q[95:0], wdata_o};
    end
  end
endmodule
`default_nettype wire

>>> hw/rtl/aes_core.sv
// Column-serial AES round datapath: one 32-bit column per cycle in the run state.
`default_nettype none
module aes_core (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  input  wire logic         dec_i,
  input  wire logic [127:0] block_i,
  input  wire logic [31:0]  rk_i,
  output logic [5:0]        rk_addr_o,
  output logic              done_o,
  output logic [127:0]      block_o
);
  import aes_pkg::*;

  typedef enum logic [1:0] {StIdle, StFetch, StRun} state_e;

  state_e       state_q;
  logic [127:0] st_q;    // round state, column 0 in the top bits
  logic [127:0] nx_q;    // next state assembled a column at a time
  logic [3:0]   round_q; // rounds done so far (0 = initial key add pending)
  logic [1:0]   col_q;
  logic         dec_q;
  logic         done_q;
  logic [31:0]  col_in, col_sr, col_sb, col_out;
  logic [127:0] nx_full;
  logic [3:0]   kr;

  // Key round in use and its address.
  assign kr = dec_q ? (4'd10 - round_q) : round_q;
  always_comb begin
    logic [3:0] kr_n;
    logic [1:0] c_n;
    kr_n = kr;
    // fetch cycle addresses column 0; each run cycle addresses the next column
    c_n  = (state_q == StRun) ? col_q + 2'd1 : 2'd0;
    rk_addr_o = {kr_n, 2'b00} + {4'd0, c_n};
  end

  always_comb begin
    logic [7:0] b [4];
    for (int r = 0; r < 4; r++) begin
      // forward: row r of col c from col c+r; inverse: from col c-r
      b[r] = dec_q ? st_q[127 - 32*((col_q - r[1:0]) & 2'd3) - 8*r -: 8]
                   : st_q[127 - 32*((col_q + r[1:0]) & 2'd3) - 8*r -: 8];
    end
    col_in = st_q[127-32*col_q -: 32];
    col_sr = {b[0], b[1], b[2], b[3]};
    for (int r = 0; r < 4; r++) begin
      col_sb[31-8*r -: 8] = dec_q ? inv_sbox_f(col_sr[31-8*r -: 8])
                                  : sbox_f(col_sr[31-8*r -: 8]);
    end
    if (round_q == 4'd0) begin
      col_out = col_in ^ rk_i;
    end else if (dec_q) begin
      col_out = (round_q == 4'd10) ? (col_sb ^ rk_i) : mix_col_f(col_sb ^ rk_i, 1'b1);
    end else begin
      col_out = (round_q == 4'd10) ? (col_sb ^ rk_i) : (mix_col_f(col_sb, 1'b0) ^ rk_i);
    end
    nx_full = nx_q;
    nx_full[127-32*col_q -: 32] = col_out;
  end

  assign done_o  = done_q;
  assign block_o = st_q;

  // RAM read is registered: the address is presented in the cycle before its column is used.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      round_q <= '0;
      col_q   <= '0;
      dec_q   <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        StIdle: begin
          if (start_i) begin
            dec_q   <= dec_i;
            round_q <= '0;
            col_q   <= '0;
            state_q <= StFetch;
          end
        end
        StFetch: state_q <= StRun;
        StRun: begin
          col_q <= col_q + 2'd1;
          if (col_q == 2'd3) begin
            if (round_q == 4'd10) begin
              state_q <= StIdle;
              done_q  <= 1'b1;
            end else begin
              round_q <= round_q + 4'd1;
              state_q <= StFetch;
            end
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && start_i) begin
      st_q <= block_i;
    end else if (state_q == StRun) begin
      if (col_q == 2'd3) st_q <= nx_full;
      else nx_q <= nx_full;
    end
  end
endmodule
`default_nettype wire

>>> hw/rtl/aes128_cbc_block_cipher_unit.sv
// Top level of the AES-128 CBC block cipher unit.
`default_nettype none
// AES-128 in CBC mode with an all-zero IV. Write the key through the config
// channel (index 0 = key bytes 0..7, index 1 = bytes 8..15, byte 0 in the
// MSBs); each write re-expands the key into a 44-word RAM, one word per
// cycle, during which no item is taken; expansion also runs
// after reset for the all-zero key. Key writes are held off while a block is
// in flight, and a pending key write takes priority over a new item. Each
// input item carries one 128-bit block, an opcode (0 encrypt, 1 decrypt) and
// a first-block flag that clears the chaining value. The round datapath
// handles one 32-bit column per cycle in its run state and reads one
// round-key word per cycle from the key RAM, so an item takes 11 rounds in
// the core, each a RAM fetch plus four columns; the core's registered done
// strobe then loads the result register, which offers the result. One block
// is in flight at a time and the input stays closed until the result is
// taken, so each output stall also holds off the next item. The chain is
// not restarted on a direction change unless first_block is set.
module aes128_cbc_block_cipher_unit (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          s_axis_tvalid,
  output logic               s_axis_tready,
  input  wire logic [127:0]  s_axis_tdata,   // data_high, data_low (low bits first: data_high)
  input  wire logic [1:0]    s_axis_tuser,   // opcode, first_block
  output logic               m_axis_tvalid,
  input  wire logic          m_axis_tready,
  output logic [127:0]       m_axis_tdata,   // result_high, result_low
  input  wire logic          cfg_valid_i,
  output logic               cfg_ready_o,
  input  wire logic [aes_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [63:0]   cfg_data_i
);
  import aes_pkg::*;

  logic [63:0]  key_hi_q, key_lo_q;
  logic [127:0] chain_q;
  logic [127:0] in_blk_q;
  logic         dec_q;
  logic         busy_q;
  logic         out_v_q;
  logic [127:0] out_q;
  logic         cfg_we, in_acc, core_start, core_done;
  logic         kx_busy, kx_we;
  logic [5:0]   kx_addr, core_addr, ram_addr;
  logic [31:0]  kx_wdata, rk;
  logic [127:0] core_in, core_out, dh_dl, xin;
  logic [127:0] chain_use;

  // Key writes only between blocks; the round keys must not move under a block.
  assign cfg_ready_o = !busy_q;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  // tdata: data_high in [63:0], data_low in [127:64]; internal block is high-first.
  assign dh_dl     = {s_axis_tdata[63:0], s_axis_tdata[127:64]};
  assign chain_use = s_axis_tuser[1] ? '0 : chain_q;

  assign s_axis_tready = !busy_q && !kx_busy && !out_v_q && !cfg_valid_i;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign xin           = (s_axis_tuser[0] == OpDecrypt) ? dh_dl : (dh_dl ^ chain_use);
  assign core_in       = xin;
  assign core_start    = in_acc;

  assign ram_addr = kx_busy ? kx_addr : core_addr;

  aes_key_exp u_kx (
    .clk_i,
    .rst_ni,
    .start_i (cfg_we),
    .key_i   ({key_hi_q, key_lo_q}),
    .busy_o  (kx_busy),
    .we_o    (kx_we),
    .addr_o  (kx_addr),
    .wdata_o (kx_wdata)
  );

  aes_ram #(.Width(32), .Depth(44)) u_rk (
    .clk_i,
    .we_i    (kx_we),
    .addr_i  (ram_addr),
    .wdata_i (kx_wdata),
    .rdata_o (rk)
  );

  aes_core u_core (
    .clk_i,
    .rst_ni,
    .start_i   (core_start),
    .dec_i     (s_axis_tuser[0]),
    .block_i   (core_in),
    .rk_i      (rk),
    .rk_addr_o (core_addr),
    .done_o    (core_done),
    .block_o   (core_out)
  );

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {out_q[63:0], out_q[127:64]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_hi_q <= '0;
      key_lo_q <= '0;
      chain_q  <= '0;
      busy_q   <= 1'b0;
      out_v_q  <= 1'b0;
      dec_q    <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index_i)
          RegKeyHigh: key_hi_q <= cfg_data_i;
          RegKeyLow:  key_lo_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (in_acc) begin
        busy_q <= 1'b1;
        dec_q  <= s_axis_tuser[0];
        if (s_axis_tuser[1]) chain_q <= '0;
      end
      if (core_done) begin
        busy_q  <= 1'b0;
        out_v_q <= 1'b1;
        if (dec_q == OpDecrypt) chain_q <= in_blk_q;
        else chain_q <= core_out;
      end else if (m_axis_tready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) in_blk_q <= dh_dl;
    if (core_done) out_q <= (dec_q == OpDecrypt) ? (core_out ^ chain_q) : core_out;
  end

  // A result only appears while a block is in flight.
  assert property (@(posedge clk_i) disable iff (!rst_ni) core_done |-> busy_q)
    else $error("core finished with no block in flight");
  // No item is taken while the key is being expanded.
  assert property (@(posedge clk_i) disable iff (!rst_ni) kx_busy |-> !in_acc)
    else $error("item accepted during key expansion");
  // No key write lands while a block is in flight.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cfg_we |-> !busy_q && !in_acc)
    else $error("key written with a block in flight");
  // Once a result is shown it stays until taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !m_axis_tready) |=> out_v_q)
    else $error("result dropped before taken");
endmodule
`default_nettype wire
